@@ rtl/core/mvlc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvlc_pkg
// Shared codes, widths and register defaults of the motor valve controller.
// ----------------------------------------------------------------------------
package mvlc_pkg;

    localparam int TIMER_W = 12;
    localparam int POLLC_W = 13;
    localparam int PHASE_W = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE   = 4'd0;
    localparam logic [PHASE_W-1:0] PH_PRE    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_WAKE   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_CHECK  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_DEB    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_POLL   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_BRAKE  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TAIL   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SETTLE = 4'd8;
    localparam logic [PHASE_W-1:0] PH_PWAKE  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_PCHECK = 4'd10;
    localparam logic [PHASE_W-1:0] PH_PDEB   = 4'd11;
    localparam logic [PHASE_W-1:0] PH_PPOLL  = 4'd12;
    localparam logic [PHASE_W-1:0] PH_PBRAKE = 4'd13;

    // item kinds
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_OPEN    = 2'd1;
    localparam logic [1:0] OP_CLOSE   = 2'd2;
    localparam logic [1:0] OP_PARTIAL = 2'd3;

    // bridge pins: bit 0 awake, bit 1 A (close), bit 2 B (open)
    localparam logic [2:0] PIN_OFF   = 3'b000;
    localparam logic [2:0] PIN_AWAKE = 3'b001;
    localparam logic [2:0] PIN_A     = 3'b010;
    localparam logic [2:0] PIN_B     = 3'b100;
    localparam logic [2:0] PIN_BRAKE = 3'b111;

    // completion status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_OPENHIT = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_POLL       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_POLL_LIMIT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BRAKE      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_WAKE       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE     = 3'd5;

    localparam logic [7:0]  DEF_DEBOUNCE   = 8'd20;
    localparam logic [7:0]  DEF_POLL       = 8'd10;
    localparam logic [11:0] DEF_POLL_LIMIT = 12'd1500;
    localparam logic [11:0] DEF_BRAKE      = 12'd500;
    localparam logic [7:0]  DEF_WAKE       = 8'd10;
    localparam logic [11:0] DEF_SETTLE     = 12'd1000;

    typedef struct packed {
        logic [7:0]  debounce_ms;
        logic [7:0]  poll_ms;
        logic [11:0] poll_limit;
        logic [11:0] brake_ms;
        logic [7:0]  wake_ms;
        logic [11:0] settle_ms;
    } cfg_t;

endpackage

@@ rtl/core/motor_valve_limit_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_valve_limit_controller_top
// Open / close / partial-open sequencer for a DC-motor valve on an H-bridge.
// ----------------------------------------------------------------------------
// Every accepted item (a 1 ms tick or a command) yields exactly one result
// item carrying the bridge pins and busy/done/status. One item per clock
// unless a result sits unread: the whole sequencer step, including chains
// of zero-length waits, is combinational between the state registers and
// the result register. The input side stalls only while a result sits unread.
// Configuration writes are taken at any cycle and should be made while idle.
module motor_valve_limit_controller_top #(
    parameter int PARTIAL_TIME_BITS = 20
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic [mvlc_pkg::CFG_ADDR_W-1:0]               cfg_addr,
    input  logic [mvlc_pkg::CFG_DATA_W-1:0]               cfg_wdata,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // open_switch_n, closed_switch_n, partial_ms, zero fill
    input  logic [((PARTIAL_TIME_BITS + 9) / 8) * 8 - 1:0] s_tdata,
    // op
    input  logic [1:0]                                    s_tuser,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // motor_awake, drive_a, drive_b, busy_res, done_res, status, zero fill
    output logic [7:0]                                    m_tdata
);
    import mvlc_pkg::*;

    localparam int PT_W = PARTIAL_TIME_BITS;
    localparam int STEPS = 8;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [1:0]         command;
        logic [TIMER_W-1:0] timer;
        logic [PT_W-1:0]    elapsed;
        logic [POLLC_W-1:0] pollc;
        logic [2:0]         pins;
        logic [1:0]         fstat;
        logic [PT_W-1:0]    target;
    } seq_t;

    typedef struct packed {
        seq_t s;
        logic run;
        logic done;
    } step_t;

    cfg_t        cfg_reg;
    seq_t        state_reg;
    seq_t        state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_data_reg;
    logic [7:0]  out_data_next;
    logic        accept;
    logic [1:0]  op;
    logic        open_n;
    logic        closed_n;
    logic [PT_W-1:0] partial_ms;
    step_t       chain [0:STEPS];

    assign op         = s_tuser;
    assign open_n     = s_tdata[0];
    assign closed_n   = s_tdata[1];
    assign partial_ms = s_tdata[PT_W+1:2];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    function automatic step_t finish(step_t x, logic [1:0] st);
        step_t n;
        n         = x;
        n.s.pins  = PIN_OFF;
        n.s.fstat = st;
        n.done    = 1'b1;
        n.s.phase = PH_IDLE;
        n.s.timer = '0;
        return n;
    endfunction

    function automatic step_t full_success(step_t x, cfg_t c);
        step_t n;
        n = x;
        if (x.s.command == OP_PARTIAL)
        begin
            n.s.phase = PH_SETTLE;
            n.s.timer = c.settle_ms;
        end
        else
        begin
            n = finish(x, ST_OK);
        end
        return n;
    endfunction

    function automatic step_t step(step_t x, cfg_t c, logic o_n, logic c_n);
        step_t              n;
        logic               tlow;
        logic               olow;
        logic               tz;
        logic [TIMER_W-1:0] pp;
        n    = x;
        olow = !o_n;
        tlow = (x.s.command == OP_OPEN) ? !o_n : !c_n;
        tz   = (x.s.timer == '0);
        pp   = {4'd0, (c.poll_ms == 8'd0) ? 8'd1 : c.poll_ms};
        if (x.run)
        begin
            unique case (x.s.phase)
                PH_PRE:
                begin
                    if (!tz)
                        n.run = 1'b0;
                    else if (tlow)
                        n = full_success(x, c);
                    else
                    begin
                        n.s.pins  = PIN_AWAKE;
                        n.s.phase = PH_WAKE;
                        n.s.timer = {4'd0, c.wake_ms};
                    end
                end
                PH_WAKE:
                begin
                    if (!tz)
                        n.run = 1'b0;
                    else
                    begin
                        n.s.pins  = PIN_AWAKE | ((x.s.command == OP_OPEN) ? PIN_B : PIN_A);
                        n.s.pollc = '0;
                        n.s.phase = PH_CHECK;
                        n.s.timer = '0;
                    end
                end
                PH_CHECK:
                begin
                    if (x.s.pollc > {1'b0, c.poll_limit})
                        n = finish(x, ST_TIMEOUT);
                    else if (tlow)
                    begin
                        n.s.phase = PH_DEB;
                        n.s.timer = {4'd0, c.debounce_ms};
                    end
                    else
                    begin
                        n.s.phase = PH_POLL;
                        n.s.timer = pp;
                    end
                end
                PH_DEB:
                begin
                    if (!tz)
                        n.run = 1'b0;
                    else if (tlow)
                    begin
                        n.s.pins  = PIN_BRAKE;
                        n.s.phase = PH_BRAKE;
                        n.s.timer = c.brake_ms;
                    end
                    else
                    begin
                        n.s.phase = PH_POLL;
                        n.s.timer = pp;
                    end
                end
                PH_POLL:
                begin
                    if (!tz)
                        n.run = 1'b0;
                    else
                    begin
                        n.s.pollc = x.s.pollc + 1'b1;
                        n.s.phase = PH_CHECK;
                    end
                end
                PH_BRAKE:
                begin
                    if (!tz)
                        n.run = 1'b0;
                    else
                    begin
                        n.s.pins  = PIN_OFF;
                        n.s.phase = PH_TAIL;
                        n.s.timer = pp;
                    end
                end
                PH_TAIL:
                begin
                    if (!tz)
                        n.run = 1'b0;
                    else
                        n = full_success(x, c);
                end
                PH_SETTLE:
                begin
                    if (!tz)
                        n.run = 1'b0;
                    else
                    begin
                        n.s.pins  = PIN_AWAKE;
                        n.s.phase = PH_PWAKE;
                        n.s.timer = {4'd0, c.wake_ms};
                    end
                end
                PH_PWAKE:
                begin
                    if (!tz)
                        n.run = 1'b0;
                    else
                    begin
                        n.s.pins    = PIN_AWAKE | PIN_B;
                        n.s.elapsed = '0;
                        n.s.phase   = PH_PCHECK;
                    end
                end
                PH_PCHECK:
                begin
                    if (x.s.elapsed >= x.s.target)
                    begin
                        n.s.pins  = PIN_BRAKE;
                        n.s.fstat = ST_OK;
                        n.s.phase = PH_PBRAKE;
                        n.s.timer = c.brake_ms;
                    end
                    else if (olow)
                    begin
                        n.s.phase = PH_PDEB;
                        n.s.timer = {4'd0, c.debounce_ms};
                    end
                    else
                    begin
                        n.s.phase = PH_PPOLL;
                        n.s.timer = pp;
                    end
                end
                PH_PDEB:
                begin
                    if (!tz)
                        n.run = 1'b0;
                    else if (olow)
                    begin
                        n.s.pins  = PIN_BRAKE;
                        n.s.fstat = ST_OPENHIT;
                        n.s.phase = PH_PBRAKE;
                        n.s.timer = c.brake_ms;
                    end
                    else
                    begin
                        n.s.phase = PH_PPOLL;
                        n.s.timer = pp;
                    end
                end
                PH_PPOLL:
                begin
                    if (!tz)
                        n.run = 1'b0;
                    else
                        n.s.phase = PH_PCHECK;
                end
                PH_PBRAKE:
                begin
                    if (!tz)
                        n.run = 1'b0;
                    else
                        n = finish(x, x.s.fstat);
                end
                default:
                begin
                    n.s.phase = PH_IDLE;
                    n.run     = 1'b0;
                end
            endcase
        end
        return n;
    endfunction

    // item entry, then a bounded chain of zero-wait transitions
    always_comb
    begin
        chain[0].s    = state_reg;
        chain[0].run  = 1'b0;
        chain[0].done = 1'b0;
        if (accept)
        begin
            if (op == OP_TICK)
            begin
                if (state_reg.phase != PH_IDLE)
                begin
                    chain[0].run = 1'b1;
                    if ((state_reg.phase == PH_PDEB || state_reg.phase == PH_PPOLL)
                        && state_reg.elapsed != '1)
                        chain[0].s.elapsed = state_reg.elapsed + 1'b1;
                    if (state_reg.timer != '0)
                        chain[0].s.timer = state_reg.timer - 1'b1;
                end
            end
            else if (state_reg.phase == PH_IDLE)
            begin
                chain[0].run       = 1'b1;
                chain[0].s.command = op;
                chain[0].s.target  = partial_ms;
                chain[0].s.fstat   = ST_OK;
                chain[0].s.phase   = PH_PRE;
                // a high target switch skips the initial debounce
                if ((op == OP_OPEN) ? open_n : closed_n)
                    chain[0].s.timer = '0;
                else
                    chain[0].s.timer = {4'd0, cfg_reg.debounce_ms};
            end
        end
        for (int i = 0; i < STEPS; i++)
            chain[i+1] = step(chain[i], cfg_reg, open_n, closed_n);
        state_next = chain[STEPS].s;
        out_data_next = {1'b0,
                         chain[STEPS].done ? chain[STEPS].s.fstat : ST_OK,
                         chain[STEPS].done,
                         chain[STEPS].s.phase != PH_IDLE,
                         chain[STEPS].s.pins[2],
                         chain[STEPS].s.pins[1],
                         chain[STEPS].s.pins[0]};
        if (accept)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms <= DEF_DEBOUNCE;
            cfg_reg.poll_ms     <= DEF_POLL;
            cfg_reg.poll_limit  <= DEF_POLL_LIMIT;
            cfg_reg.brake_ms    <= DEF_BRAKE;
            cfg_reg.wake_ms     <= DEF_WAKE;
            cfg_reg.settle_ms   <= DEF_SETTLE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DEBOUNCE:   cfg_reg.debounce_ms <= cfg_wdata[7:0];
                REG_POLL:       cfg_reg.poll_ms     <= cfg_wdata[7:0];
                REG_POLL_LIMIT: cfg_reg.poll_limit  <= cfg_wdata;
                REG_BRAKE:      cfg_reg.brake_ms    <= cfg_wdata;
                REG_WAKE:       cfg_reg.wake_ms     <= cfg_wdata[7:0];
                REG_SETTLE:     cfg_reg.settle_ms   <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

endmodule

@@ tb/sv/tb_motor_valve_limit_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_valve_limit_controller_top
// Self-checking bench for the valve sequencer: open, close and partial open
// runs against switch patterns, with an item-level model of the sequencer
// predicting the bridge pins and busy/done/status of every result item.
// ----------------------------------------------------------------------------
module tb_motor_valve_limit_controller_top;

    import mvlc_pkg::*;

    localparam int PT_BITS = 20;
    localparam int DATA_W = ((PT_BITS + 9) / 8) * 8;
    localparam int PT_MAX = (1 << PT_BITS) - 1;
    localparam int PHASE_ITEMS = 110;

    typedef struct {
        logic [1:0]         op;
        logic               open_n;
        logic               closed_n;
        logic [PT_BITS-1:0] partial_ms;
    } valve_item_t;

    typedef struct {
        logic       awake;
        logic       drive_a;
        logic       drive_b;
        logic       busy;
        logic       done;
        logic [1:0] status;
    } valve_out_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic [1:0]        s_tuser = OP_TICK;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;

    motor_valve_limit_controller_top #(
        .PARTIAL_TIME_BITS(PT_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------
    cfg_t             valve_cfg;
    logic [PHASE_W-1:0] seq_phase = PH_IDLE;
    logic [1:0]       seq_cmd = OP_TICK;
    int               seq_timer = 0;
    int               seq_elapsed = 0;
    int               seq_polls = 0;
    logic [2:0]       seq_pins = PIN_OFF;
    logic [1:0]       seq_status = ST_OK;
    int               seq_target = 0;
    bit               seq_done = 1'b0;

    valve_item_t pending_items[$];
    valve_out_t  expected_outs[$];
    valve_item_t cur_item;
    bit          have_item = 1'b0;
    int          n_sent = 0;
    int          n_got = 0;
    int          errors = 0;

    function automatic int poll_period();
        return (valve_cfg.poll_ms == 0) ? 1 : int'(valve_cfg.poll_ms);
    endfunction

    function automatic void goto_phase(logic [PHASE_W-1:0] ph, int t);
        seq_phase = ph;
        seq_timer = t;
    endfunction

    function automatic void end_command(logic [1:0] st);
        seq_pins = PIN_OFF;
        seq_status = st;
        seq_done = 1'b1;
        seq_phase = PH_IDLE;
        seq_timer = 0;
    endfunction

    function automatic void travel_done();
        if (seq_cmd == OP_PARTIAL)
            goto_phase(PH_SETTLE, int'(valve_cfg.settle_ms));
        else
            end_command(ST_OK);
    endfunction

    function automatic void run_sequencer(logic open_n, logic closed_n);
        bit tgt_low;
        bit open_low;
        bit going;
        tgt_low = (seq_cmd == OP_OPEN) ? !open_n : !closed_n;
        open_low = !open_n;
        going = 1'b1;
        while (going) begin
            case (seq_phase)
                PH_PRE:
                    if (seq_timer != 0) going = 1'b0;
                    else if (tgt_low) travel_done();
                    else
                    begin
                        seq_pins = PIN_AWAKE;
                        goto_phase(PH_WAKE, int'(valve_cfg.wake_ms));
                    end
                PH_WAKE:
                    if (seq_timer != 0) going = 1'b0;
                    else
                    begin
                        seq_pins = PIN_AWAKE | ((seq_cmd == OP_OPEN) ? PIN_B : PIN_A);
                        seq_polls = 0;
                        goto_phase(PH_CHECK, 0);
                    end
                PH_CHECK:
                    if (seq_polls > int'(valve_cfg.poll_limit)) end_command(ST_TIMEOUT);
                    else if (tgt_low) goto_phase(PH_DEB, int'(valve_cfg.debounce_ms));
                    else goto_phase(PH_POLL, poll_period());
                PH_DEB:
                    if (seq_timer != 0) going = 1'b0;
                    else if (tgt_low)
                    begin
                        seq_pins = PIN_BRAKE;
                        goto_phase(PH_BRAKE, int'(valve_cfg.brake_ms));
                    end
                    else goto_phase(PH_POLL, poll_period());
                PH_POLL:
                    if (seq_timer != 0) going = 1'b0;
                    else
                    begin
                        seq_polls++;
                        goto_phase(PH_CHECK, 0);
                    end
                PH_BRAKE:
                    if (seq_timer != 0) going = 1'b0;
                    else
                    begin
                        seq_pins = PIN_OFF;
                        goto_phase(PH_TAIL, poll_period());
                    end
                PH_TAIL:
                    if (seq_timer != 0) going = 1'b0;
                    else travel_done();
                PH_SETTLE:
                    if (seq_timer != 0) going = 1'b0;
                    else
                    begin
                        seq_pins = PIN_AWAKE;
                        goto_phase(PH_PWAKE, int'(valve_cfg.wake_ms));
                    end
                PH_PWAKE:
                    if (seq_timer != 0) going = 1'b0;
                    else
                    begin
                        seq_pins = PIN_AWAKE | PIN_B;
                        seq_elapsed = 0;
                        goto_phase(PH_PCHECK, 0);
                    end
                PH_PCHECK:
                    if (seq_elapsed >= seq_target)
                    begin
                        seq_pins = PIN_BRAKE;
                        seq_status = ST_OK;
                        goto_phase(PH_PBRAKE, int'(valve_cfg.brake_ms));
                    end
                    else if (open_low) goto_phase(PH_PDEB, int'(valve_cfg.debounce_ms));
                    else goto_phase(PH_PPOLL, poll_period());
                PH_PDEB:
                    if (seq_timer != 0) going = 1'b0;
                    else if (open_low)
                    begin
                        seq_pins = PIN_BRAKE;
                        seq_status = ST_OPENHIT;
                        goto_phase(PH_PBRAKE, int'(valve_cfg.brake_ms));
                    end
                    else goto_phase(PH_PPOLL, poll_period());
                PH_PPOLL:
                    if (seq_timer != 0) going = 1'b0;
                    else goto_phase(PH_PCHECK, 0);
                PH_PBRAKE:
                    if (seq_timer != 0) going = 1'b0;
                    else end_command(seq_status);
                default:
                begin
                    seq_phase = PH_IDLE;
                    going = 1'b0;
                end
            endcase
        end
    endfunction

    function automatic valve_out_t valve_step(valve_item_t it);
        valve_out_t o;
        seq_done = 1'b0;
        if (it.op == OP_TICK)
        begin
            if (seq_phase != PH_IDLE)
            begin
                if ((seq_phase == PH_PDEB || seq_phase == PH_PPOLL) && seq_elapsed < PT_MAX)
                    seq_elapsed++;
                if (seq_timer != 0)
                    seq_timer--;
                run_sequencer(it.open_n, it.closed_n);
            end
        end
        else if (seq_phase == PH_IDLE)
        begin
            seq_cmd = it.op;
            seq_target = int'(it.partial_ms);
            seq_status = ST_OK;
            goto_phase(PH_PRE, int'(valve_cfg.debounce_ms));
            // switch already high: skip the debounce and wake at once
            if ((it.op == OP_OPEN) ? it.open_n : it.closed_n)
                seq_timer = 0;
            run_sequencer(it.open_n, it.closed_n);
        end
        o.awake = seq_pins[0];
        o.drive_a = seq_pins[1];
        o.drive_b = seq_pins[2];
        o.busy = (seq_phase != PH_IDLE);
        o.done = seq_done;
        o.status = seq_done ? seq_status : ST_OK;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // driver and monitor
    // ------------------------------------------------------------------
    function automatic bit take_gap(int n);
        if (n >= 600 && n < 900)
            return 1'b0;
        return ($urandom_range(0, 99) < 34);
    endfunction

    function automatic logic [DATA_W-1:0] pack_item(valve_item_t it);
        logic [DATA_W-1:0] d;
        d = '0;
        d[PT_BITS+1:0] = {it.partial_ms, it.closed_n, it.open_n};
        return d;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_outs.push_back(valve_step(cur_item));
                have_item = 1'b0;
                n_sent++;
            end
            if (!have_item && pending_items.size() != 0 && !take_gap(n_sent))
            begin
                cur_item = pending_items.pop_front();
                have_item = 1'b1;
            end
            s_tvalid <= have_item;
            if (have_item)
            begin
                s_tdata <= pack_item(cur_item);
                s_tuser <= cur_item.op;
            end
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s at result %0d: got %0d, expected %0d", what, n_got, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        valve_out_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_outs.size() == 0)
                    report_mismatch("unexpected item", int'(m_tdata), 0);
                else
                begin
                    want = expected_outs.pop_front();
                    if (m_tdata[0] !== want.awake)
                        report_mismatch("motor_awake", int'(m_tdata[0]), int'(want.awake));
                    if (m_tdata[1] !== want.drive_a)
                        report_mismatch("drive_a", int'(m_tdata[1]), int'(want.drive_a));
                    if (m_tdata[2] !== want.drive_b)
                        report_mismatch("drive_b", int'(m_tdata[2]), int'(want.drive_b));
                    if (m_tdata[3] !== want.busy)
                        report_mismatch("busy", int'(m_tdata[3]), int'(want.busy));
                    if (m_tdata[4] !== want.done)
                        report_mismatch("done", int'(m_tdata[4]), int'(want.done));
                    if (m_tdata[6:5] !== want.status)
                        report_mismatch("status", int'(m_tdata[6:5]), int'(want.status));
                end
                n_got++;
            end
            m_tready <= !take_gap(n_got);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(logic [1:0] op, logic open_n, logic closed_n,
                              logic [PT_BITS-1:0] pt);
        valve_item_t it;
        it.op = op;
        it.open_n = open_n;
        it.closed_n = closed_n;
        it.partial_ms = pt;
        pending_items.push_back(it);
    endtask

    function automatic logic [1:0] any_command();
        case ($urandom_range(0, 2))
            0: return OP_OPEN;
            1: return OP_CLOSE;
            default: return OP_PARTIAL;
        endcase
    endfunction

    function automatic logic [PT_BITS-1:0] any_partial();
        if ($urandom_range(0, 19) == 0)
            return PT_BITS'($urandom);
        return PT_BITS'($urandom_range(0, 40));
    endfunction

    task automatic wait_drained();
        do @(posedge clk);
        while (pending_items.size() != 0 || have_item || expected_outs.size() != 0);
    endtask

    // both switches low finishes any sequence within its configured waits
    task automatic run_to_idle();
        int i;
        wait_drained();
        while (seq_phase != PH_IDLE) begin
            for (i = 0; i < 32; i++)
                queue_item(OP_TICK, 1'b0, 1'b0, '0);
            wait_drained();
        end
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
    endtask

    task automatic load_config(cfg_t c);
        write_reg(REG_DEBOUNCE, CFG_DATA_W'(c.debounce_ms));
        write_reg(REG_POLL, CFG_DATA_W'(c.poll_ms));
        write_reg(REG_POLL_LIMIT, c.poll_limit);
        write_reg(REG_BRAKE, c.brake_ms);
        write_reg(REG_WAKE, CFG_DATA_W'(c.wake_ms));
        write_reg(REG_SETTLE, c.settle_ms);
        @(posedge clk);
        cfg_we <= 1'b0;
        valve_cfg = c;
    endtask

    // one command followed by a switch pattern: target end reached after a
    // random travel (or never), with glitches and stray commands mixed in
    task automatic queue_episode(output int count);
        valve_item_t it;
        logic [1:0] cmd;
        logic tgt_n;
        int len;
        int t_tgt;
        int t_open;
        int i;
        cmd = any_command();
        t_tgt = ($urandom_range(0, 4) == 0) ? 1000000 : $urandom_range(0, 50);
        t_open = ($urandom_range(0, 2) == 0) ? 1000000 : $urandom_range(0, 120);
        len = $urandom_range(10, 120);
        for (i = 0; i <= len; i++) begin
            tgt_n = (i >= t_tgt) ? 1'b0 : 1'b1;
            if ($urandom_range(0, 19) == 0)
                tgt_n = ~tgt_n;
            if (cmd == OP_OPEN)
            begin
                it.open_n = tgt_n;
                it.closed_n = ($urandom_range(0, 9) != 0);
            end
            else
            begin
                it.closed_n = tgt_n;
                if (cmd == OP_PARTIAL && i >= t_open)
                    it.open_n = ($urandom_range(0, 19) == 0);
                else
                    it.open_n = ($urandom_range(0, 9) != 0);
            end
            it.op = (i == 0) ? cmd : OP_TICK;
            if (i != 0 && $urandom_range(0, 29) == 0)
                it.op = any_command();
            it.partial_ms = any_partial();
            pending_items.push_back(it);
        end
        for (i = $urandom_range(0, 5); i > 0; i--) begin
            it.op = $urandom_range(0, 1) ? OP_TICK : any_command();
            it.open_n = 1'($urandom_range(0, 1));
            it.closed_n = 1'($urandom_range(0, 1));
            it.partial_ms = PT_BITS'($urandom);
            pending_items.push_back(it);
            len++;
        end
        count = len + 1;
    endtask

    initial
    begin
        cfg_t c;
        int p;
        int n;
        int added;

        valve_cfg.debounce_ms = DEF_DEBOUNCE;
        valve_cfg.poll_ms = DEF_POLL;
        valve_cfg.poll_limit = DEF_POLL_LIMIT;
        valve_cfg.brake_ms = DEF_BRAKE;
        valve_cfg.wake_ms = DEF_WAKE;
        valve_cfg.settle_ms = DEF_SETTLE;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults: open from mid travel, stray command while busy
        queue_item(OP_OPEN, 1'b1, 1'b1, '0);
        queue_item(OP_OPEN, 1'b0, 1'b1, '0);
        run_to_idle();

        // all registers zero: no waits but the minimum poll period, poll limit zero
        c = '0;
        load_config(c);
        queue_item(OP_TICK, 1'b1, 1'b1, '0);
        queue_item(OP_OPEN, 1'b0, 1'b1, '0);
        queue_item(OP_CLOSE, 1'b1, 1'b0, '0);
        queue_item(OP_PARTIAL, 1'b1, 1'b0, '0);
        queue_item(OP_OPEN, 1'b1, 1'b0, '0);
        queue_item(OP_CLOSE, 1'b1, 1'b1, '0);
        queue_item(OP_TICK, 1'b1, 1'b1, '0);
        queue_item(OP_PARTIAL, 1'b1, 1'b1, '1);
        queue_item(OP_TICK, 1'b1, 1'b0, '1);
        queue_item(OP_PARTIAL, 1'b0, 1'b0, 20'd5);
        queue_item(OP_PARTIAL, 1'b1, 1'b0, '1);
        queue_item(OP_TICK, 1'b1, 1'b1, '0);
        queue_item(OP_OPEN, 1'b1, 1'b1, '0);
        queue_item(OP_TICK, 1'b1, 1'b1, '0);
        queue_item(OP_TICK, 1'b0, 1'b0, '0);
        queue_item(OP_CLOSE, 1'b1, 1'b1, '0);
        queue_item(OP_TICK, 1'b0, 1'b0, '0);
        queue_item(OP_TICK, 1'b0, 1'b0, '0);
        run_to_idle();

        // every register at its top value: a close that starts at its end
        c.debounce_ms = 8'hFF;
        c.poll_ms = 8'hFF;
        c.poll_limit = 12'hFFF;
        c.brake_ms = 12'hFFF;
        c.wake_ms = 8'hFF;
        c.settle_ms = 12'hFFF;
        load_config(c);
        queue_item(OP_CLOSE, 1'b1, 1'b0, '0);
        queue_item(OP_PARTIAL, 1'b1, 1'b1, 20'd300);
        run_to_idle();

        // random phases with short timings so sequences complete often
        for (p = 0; p < 5; p++) begin
            c.debounce_ms = 8'($urandom_range(0, 6));
            c.poll_ms = 8'($urandom_range(0, 5));
            c.poll_limit = 12'($urandom_range(0, 30));
            c.brake_ms = 12'($urandom_range(0, 12));
            c.wake_ms = 8'($urandom_range(0, 6));
            c.settle_ms = 12'($urandom_range(0, 12));
            load_config(c);
            n = 0;
            while (n < PHASE_ITEMS) begin
                queue_episode(added);
                n += added;
            end
            run_to_idle();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb_motor_valve_limit_controller_top: clean");
        else
            $display("tb_motor_valve_limit_controller_top: errors");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb_motor_valve_limit_controller_top: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mvlc_pkg.sv
rtl/core/motor_valve_limit_controller_top.sv
tb/sv/tb_motor_valve_limit_controller_top.sv
